// File: rtl/kvt_pkg.sv
package kvt_pkg;

    localparam int TBL_DEPTH = 16;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int MAX_RES   = 16;
    localparam int KEY_W     = 8;
    localparam int VAL_W     = 16;
    localparam int FUNC_W    = 3;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_GET    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_LIST   = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key_in;
        logic [VAL_W-1:0]  value_in;
    } t_in;

    typedef struct packed {
        logic              ok;
        logic [IDX_W-1:0]  slot_index;
        logic [VAL_W-1:0]  value_out;
        logic [KEY_W-1:0]  listed_key;
        logic [CNT_W-1:0]  entry_count;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_mem_req;

endpackage

// File: rtl/kvt_mem.sv
module kvt_mem (
    input  logic              i_clk,
    input  kvt_pkg::t_mem_req i_req,
    output kvt_pkg::t_entry   o_rd_data
);

    kvt_pkg::t_entry mem [kvt_pkg::TBL_DEPTH];
    kvt_pkg::t_entry r_rd_data;

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/kvt_out.sv
module kvt_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kvt_pkg::t_out i_data,
    output logic          o_free,
    output logic          o_valid,
    input  logic          i_stall,
    output kvt_pkg::t_out o_data
);

    logic          r_vld;
    logic          n_vld;
    kvt_pkg::t_out r_data;

    // free when empty or when the held item leaves this cycle
    assign o_free = !r_vld || !i_stall;

    always_comb begin
        n_vld = r_vld;
        if (i_push) begin
            n_vld = 1'b1;
        end else if (!i_stall) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule

// File: rtl/small_key_value_table_core.sv
// sequence: an item is taken in the idle state, then the slot scan reads one slot per cycle
// through the registered table memory unless a list waits on the result side, then the
// result register is loaded; a clear or an unknown operation skips the scan
// flow: one item at a time, the input stalls until the result is pushed; the single read
// port paces the scan, and a list also waits on the result side for each listed key
// reset: synchronous, active low; all slot valid bits drop, so the table reads as empty
module small_key_value_table_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  kvt_pkg::t_in i_in,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output kvt_pkg::t_out o_out
);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                     r_state, n_state;
    logic [kvt_pkg::FUNC_W-1:0]     r_op, n_op;
    logic [kvt_pkg::KEY_W-1:0]      r_key, n_key;
    logic [kvt_pkg::VAL_W-1:0]      r_val, n_val;
    logic [kvt_pkg::CNT_W-1:0]      r_addr, n_addr;
    logic                           r_rd_vld, n_rd_vld;
    logic [kvt_pkg::IDX_W-1:0]      r_rd_idx, n_rd_idx;
    logic [kvt_pkg::TBL_DEPTH-1:0]  r_slot_vld, n_slot_vld;
    kvt_pkg::t_out                  r_res, n_res;
    logic                           r_pend_vld, n_pend_vld;
    kvt_pkg::t_out                  r_pend, n_pend;
    logic [kvt_pkg::CNT_W-1:0]      r_cnt, n_cnt;

    kvt_pkg::t_mem_req              mem_req;
    kvt_pkg::t_entry                rd_data;
    logic                           out_push;
    kvt_pkg::t_out                  out_data;
    logic                           out_free;

    logic [kvt_pkg::KEY_W-1:0]      cur_key;
    logic [kvt_pkg::VAL_W-1:0]      cur_val;
    logic                           key_hit;
    logic                           occupied;
    logic                           blocked;
    logic                           proc;
    logic                           stop;

    // slot memory: written only by add, read one slot per cycle during a scan unless a list stalls
    kvt_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // result register parts the scan from the downstream stall
    kvt_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_data),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out)
    );

    // a slot whose valid bit is low reads as all zero (cleared or removed)
    assign cur_key  = r_slot_vld[r_rd_idx] ? rd_data.key   : '0;
    assign cur_val  = r_slot_vld[r_rd_idx] ? rd_data.value : '0;
    assign key_hit  = (cur_key == r_key);
    assign occupied = (cur_val != '0);

    // a list hit needs room to push the previous pending key; the read data is held
    assign blocked  = (r_op == kvt_pkg::FN_LIST) && occupied && r_pend_vld && !out_free;
    assign proc     = (r_state == ST_SCAN) && r_rd_vld && !blocked;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_val      = r_val;
        n_addr     = r_addr;
        n_rd_vld   = r_rd_vld;
        n_rd_idx   = r_rd_idx;
        n_slot_vld = r_slot_vld;
        n_res      = r_res;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_cnt      = r_cnt;
        mem_req    = '0;
        out_push   = 1'b0;
        out_data   = r_res;
        stop       = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op       = i_in.func;
                    n_key      = i_in.key_in;
                    n_val      = i_in.value_in;
                    n_addr     = '0;
                    n_rd_vld   = 1'b0;
                    n_pend_vld = 1'b0;
                    n_cnt      = '0;
                    n_res      = '0;
                    n_res.last = 1'b1;
                    if (i_in.func == kvt_pkg::FN_CLEAR) begin
                        n_slot_vld = '0;
                        n_state    = ST_FIN;
                    end else if (i_in.func inside {kvt_pkg::FN_ADD, kvt_pkg::FN_REMOVE,
                                                   kvt_pkg::FN_GET, kvt_pkg::FN_LIST}) begin
                        n_state = ST_SCAN;
                    end else begin
                        // unknown operation: plain last-only item
                        n_state = ST_FIN;
                    end
                end
            end

            ST_SCAN: begin
                if (proc) begin
                    case (r_op)
                        kvt_pkg::FN_ADD: begin
                            // first free slot takes the new entry
                            if (!occupied) begin
                                mem_req.wr_en         = 1'b1;
                                mem_req.wr_addr       = r_rd_idx;
                                mem_req.wr_data.key   = r_key;
                                mem_req.wr_data.value = r_val;
                                n_slot_vld[r_rd_idx]  = 1'b1;
                                n_res.ok              = 1'b1;
                                n_res.slot_index      = r_rd_idx;
                                stop                  = 1'b1;
                            end
                        end
                        kvt_pkg::FN_REMOVE: begin
                            if (key_hit) begin
                                n_slot_vld[r_rd_idx] = 1'b0;
                            end
                        end
                        kvt_pkg::FN_GET: begin
                            if (key_hit) begin
                                n_res.value_out = cur_val;
                                stop            = 1'b1;
                            end
                        end
                        kvt_pkg::FN_LIST: begin
                            // one-deep pending stage so the final key can carry last
                            if (occupied) begin
                                if (r_pend_vld) begin
                                    out_push = 1'b1;
                                    out_data = r_pend;
                                end
                                n_cnt              = r_cnt + kvt_pkg::CNT_W'(1);
                                n_pend_vld         = 1'b1;
                                n_pend             = '0;
                                n_pend.ok          = 1'b1;
                                n_pend.listed_key  = cur_key;
                                n_pend.entry_count = n_cnt;
                                if (n_cnt == kvt_pkg::CNT_W'(kvt_pkg::MAX_RES)) begin
                                    stop = 1'b1;
                                end
                            end
                        end
                        default: begin
                            stop = 1'b1;
                        end
                    endcase
                    if (r_rd_idx == kvt_pkg::IDX_W'(kvt_pkg::TBL_DEPTH - 1)) begin
                        stop = 1'b1;
                    end
                end

                if (stop) begin
                    n_state  = ST_FIN;
                    n_rd_vld = 1'b0;
                    if (r_op == kvt_pkg::FN_LIST && n_pend_vld) begin
                        n_res      = n_pend;
                        n_res.last = 1'b1;
                    end
                end else if ((!r_rd_vld || proc)
                             && (r_addr < kvt_pkg::CNT_W'(kvt_pkg::TBL_DEPTH))) begin
                    // next slot read; writes only land on the slot just compared,
                    // never on the one being read, so no forwarding is needed
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_addr[kvt_pkg::IDX_W-1:0];
                    n_rd_idx        = r_addr[kvt_pkg::IDX_W-1:0];
                    n_rd_vld        = 1'b1;
                    n_addr          = r_addr + kvt_pkg::CNT_W'(1);
                end else if (proc) begin
                    n_rd_vld = 1'b0;
                end
            end

            ST_FIN: begin
                if (out_free) begin
                    out_push = 1'b1;
                    out_data = r_res;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rd_vld   <= 1'b0;
            r_slot_vld <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= n_rd_vld;
            r_slot_vld <= n_slot_vld;
            r_pend_vld <= n_pend_vld;
        end
    end

    // operands and working payload
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_val    <= n_val;
        r_addr   <= n_addr;
        r_rd_idx <= n_rd_idx;
        r_res    <= n_res;
        r_pend   <= n_pend;
        r_cnt    <= n_cnt;
    end

endmodule

// File: rtl/kvt_chk.sv
module kvt_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input kvt_pkg::t_in  i_in,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input kvt_pkg::t_out o_out
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result item changed while stalled");

    // one item at a time: taking an item closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after an item was taken");

    // only list items come without last, and they always carry a key
    a_list_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last |-> o_out.ok && (o_out.entry_count != '0))
        else $error("non-final item without a listed entry");

    // a slot index only comes with a successful add
    a_slot_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.slot_index != '0) |-> o_out.ok && o_out.last
            && (o_out.entry_count == '0))
        else $error("slot index outside a successful add");

endmodule

bind small_key_value_table_core kvt_chk u_kvt_chk (.*);
